// ===== hdl/b2dd_pkg.sv =====
// ----------------------------------------------------------------------------
// b2dd_pkg
// Shared constants and helpers for the binary to decimal digit converter.
// ----------------------------------------------------------------------------
package b2dd_pkg;

	// Width of the text form whose leading zeros are blanked
	localparam int DIGIT_COUNT    = 20;
	// Digits produced by the converter
	localparam int BCD_DIGITS     = 20;
	localparam int BCD_W          = 4 * BCD_DIGITS;
	localparam int SRC_W          = 64;
	// Shift-and-add-3 steps folded into each pipeline stage
	localparam int BITS_PER_STAGE = 8;
	localparam int DAB_STAGES     = SRC_W / BITS_PER_STAGE;
	localparam int SIG_W          = $clog2(BCD_DIGITS + 1);
	localparam int BLANK_CALC_W   = $clog2(DIGIT_COUNT + 1) + 1;

	// Source width codes, func[1:0]
	localparam logic [1:0] SRC_8  = 2'd0;
	localparam logic [1:0] SRC_16 = 2'd1;
	localparam logic [1:0] SRC_32 = 2'd2;
	localparam logic [1:0] SRC_64 = 2'd3;

	// func[2]
	localparam int FUNC_SIGNED_BIT = 2;

	typedef logic [BCD_W-1:0] bcd_t;
	typedef logic [SRC_W-1:0] word_t;

	function automatic word_t width_mask(input logic [1:0] sel);
		word_t m;
		case (sel)
			SRC_8:   m = word_t'(64'h0000_0000_0000_00FF);
			SRC_16:  m = word_t'(64'h0000_0000_0000_FFFF);
			SRC_32:  m = word_t'(64'h0000_0000_FFFF_FFFF);
			SRC_64:  m = '1;
			default: m = '1;
		endcase
		return m;
	endfunction

	function automatic logic top_bit(input logic [1:0] sel, input word_t v);
		logic t;
		case (sel)
			SRC_8:   t = v[7];
			SRC_16:  t = v[15];
			SRC_32:  t = v[31];
			SRC_64:  t = v[63];
			default: t = v[63];
		endcase
		return t;
	endfunction

	// One double-dabble step: correct each digit, then shift in the next bit
	function automatic bcd_t dab_step(input bcd_t b, input logic bit_in);
		bcd_t r;
		logic [3:0] d;
		r = b;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			d = b[4*k +: 4];
			if (d >= 4'd5)
				r[4*k +: 4] = d + 4'd3;
		end
		return {r[BCD_W-2:0], bit_in};
	endfunction

endpackage

// ===== hdl/binary_to_decimal_digits.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_digits
// Pipelined signed/unsigned 8/16/32/64-bit integer to 20-digit packed BCD,
// with sign flag and leading-blank count.
// ----------------------------------------------------------------------------
//  channel   signals                                    transfer when
//  -------   -----------------------------------------  --------------------
//  command   start, busy, func, raw_value               start && !busy
//  result    done, bcd_low, bcd_high, is_negative,      done (one cycle)
//            blank_count
//
// One item per cycle, since the pipeline never stalls. Each result passes through
// the masking and negation register, eight shift-and-add-3 stages of eight
// bits each, and the blank-count register.
// busy is always low: the pipeline never stalls, since results cannot be
// held off. Reset clears only the valid bits.
module binary_to_decimal_digits
	import b2dd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [63:0] raw_value,
	output logic        done,
	output logic [63:0] bcd_low,
	output logic [15:0] bcd_high,
	output logic        is_negative,
	output logic [4:0]  blank_count
);

	logic  take;
	word_t masked;
	logic  neg_in;

	logic  v_s1;
	word_t mag_s1;
	logic  neg_s1;

	logic  dab_v_s   [DAB_STAGES];
	bcd_t  dab_bcd_s [DAB_STAGES];
	word_t dab_bin_s [DAB_STAGES];
	logic  dab_neg_s [DAB_STAGES];

	bcd_t  dab_bcd_in [DAB_STAGES];
	word_t dab_bin_in [DAB_STAGES];
	bcd_t  dab_bcd_nx [DAB_STAGES];
	word_t dab_bin_nx [DAB_STAGES];

	bcd_t                    fin_bcd;
	logic [SIG_W-1:0]        sig;
	logic [BLANK_CALC_W-1:0] blank;

	assign busy = 1'b0;
	assign take = start && !busy;

	// ---- stage 1: mask to source width, take magnitude ----
	always_comb begin
		masked = raw_value & width_mask(func[1:0]);
		neg_in = func[FUNC_SIGNED_BIT] && top_bit(func[1:0], masked);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= neg_in;
		mag_s1 <= neg_in ? ((~masked + word_t'(1)) & width_mask(func[1:0])) : masked;
	end

	// ---- double-dabble stages, MSB first ----
	for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
		if (g == 0) begin : g_first
			assign dab_bcd_in[g] = '0;
			assign dab_bin_in[g] = mag_s1;
		end else begin : g_rest
			assign dab_bcd_in[g] = dab_bcd_s[g-1];
			assign dab_bin_in[g] = dab_bin_s[g-1];
		end

		always_comb begin
			dab_bcd_nx[g] = dab_bcd_in[g];
			dab_bin_nx[g] = dab_bin_in[g];
			for (int j = 0; j < BITS_PER_STAGE; j++) begin
				dab_bcd_nx[g] = dab_step(dab_bcd_nx[g], dab_bin_nx[g][SRC_W-1]);
				dab_bin_nx[g] = {dab_bin_nx[g][SRC_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dab_v_s[g] <= 1'b0;
			end else begin
				dab_v_s[g] <= (g == 0) ? v_s1 : dab_v_s[(g == 0) ? 0 : g-1];
			end
		end

		always_ff @(posedge clk) begin
			dab_bcd_s[g] <= dab_bcd_nx[g];
			dab_bin_s[g] <= dab_bin_nx[g];
			dab_neg_s[g] <= (g == 0) ? neg_s1 : dab_neg_s[(g == 0) ? 0 : g-1];
		end
	end

	// ---- last stage: significant digits and blank count ----
	always_comb begin
		fin_bcd = dab_bcd_s[DAB_STAGES-1];
		sig     = SIG_W'(1);
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (fin_bcd[4*k +: 4] != 4'd0)
				sig = SIG_W'(k + 1);
		end
		// never blank the last digit; saturate at zero
		if (BLANK_CALC_W'(DIGIT_COUNT) > BLANK_CALC_W'(sig))
			blank = BLANK_CALC_W'(DIGIT_COUNT) - BLANK_CALC_W'(sig);
		else
			blank = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dab_v_s[DAB_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		bcd_low     <= fin_bcd[63:0];
		bcd_high    <= fin_bcd[79:64];
		is_negative <= dab_neg_s[DAB_STAGES-1];
		blank_count <= blank[4:0];
	end

endmodule

// ===== sim/binary_to_decimal_digits_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_checker
// Watches the command and result channels of the converter, predicts the
// decimal digits, sign flag and blank count of every accepted command, and
// compares each result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits_checker
	import b2dd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [2:0]  func,
	input  logic [63:0] raw_value,
	input  logic        done,
	input  logic [63:0] bcd_low,
	input  logic [15:0] bcd_high,
	input  logic        is_negative,
	input  logic [4:0]  blank_count,
	output int          fail_count,
	output int          conversions_pending
);

	typedef struct packed {
		logic [63:0] low;
		logic [15:0] high;
		logic        neg;
		logic [4:0]  blank;
	} decimal_result_t;

	decimal_result_t conversions_due[$];

	function automatic decimal_result_t convert_to_decimal(input logic [2:0] f,
			input logic [63:0] v);
		logic [63:0] keep;
		logic [63:0] sign_mask;
		logic [63:0] mag;
		logic [3:0]  digit;
		int          sig_digits;
		decimal_result_t r;
		case (f[1:0])
			SRC_8:   keep = 64'h0000_0000_0000_00FF;
			SRC_16:  keep = 64'h0000_0000_0000_FFFF;
			SRC_32:  keep = 64'h0000_0000_FFFF_FFFF;
			default: keep = '1;
		endcase
		sign_mask = keep ^ (keep >> 1);
		mag = v & keep;
		r.neg = f[FUNC_SIGNED_BIT] && ((mag & sign_mask) != 64'd0);
		if (r.neg)
			mag = (~mag + 64'd1) & keep;
		r.low = '0;
		r.high = '0;
		sig_digits = 1;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			digit = 4'(mag % 64'd10);
			mag = mag / 64'd10;
			if (digit != 4'd0)
				sig_digits = k + 1;
			if (k < 16)
				r.low[4*k +: 4] = digit;
			else
				r.high[4*(k-16) +: 4] = digit;
		end
		// last digit is never blanked
		r.blank = (DIGIT_COUNT > sig_digits) ? 5'(DIGIT_COUNT - sig_digits) : 5'd0;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what,
			got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		conversions_pending = 0;
	end

	always @(posedge clk) begin
		decimal_result_t want;
		if (arst_n) begin
			if (done) begin
				if (conversions_due.size() == 0) begin
					report_mismatch("result with no command outstanding", bcd_low, '0);
				end else begin
					want = conversions_due.pop_front();
					conversions_pending--;
					if (bcd_low !== want.low)
						report_mismatch("bcd_low", bcd_low, want.low);
					if (bcd_high !== want.high)
						report_mismatch("bcd_high", 64'(bcd_high), 64'(want.high));
					if (is_negative !== want.neg)
						report_mismatch("is_negative", 64'(is_negative), 64'(want.neg));
					if (blank_count !== want.blank)
						report_mismatch("blank_count", 64'(blank_count), 64'(want.blank));
				end
			end
			if (start && !busy) begin
				conversions_due.push_back(convert_to_decimal(func, raw_value));
				conversions_pending++;
			end
		end
	end

endmodule

// ===== sim/binary_to_decimal_digits_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_digits_tb
// Drives directed and random integers of every width and sign mode into the
// converter, with random command gaps, and gives the verdict from the
// checker's mismatch count.
// ----------------------------------------------------------------------------
module binary_to_decimal_digits_tb;
	import b2dd_pkg::*;

	localparam int RANDOM_WORDS = 800;
	localparam int QUIET_WORDS  = 150;
	localparam int STALL_LIMIT  = 500;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [63:0] raw_value;
	logic        done;
	logic [63:0] bcd_low;
	logic [15:0] bcd_high;
	logic        is_negative;
	logic [4:0]  blank_count;
	int          fail_count;
	int          conversions_pending;
	int          stall_cycles;

	binary_to_decimal_digits u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.raw_value   (raw_value),
		.done        (done),
		.bcd_low     (bcd_low),
		.bcd_high    (bcd_high),
		.is_negative (is_negative),
		.blank_count (blank_count)
	);

	binary_to_decimal_digits_checker u_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.func                (func),
		.raw_value           (raw_value),
		.done                (done),
		.bcd_low             (bcd_low),
		.bcd_high            (bcd_high),
		.is_negative         (is_negative),
		.blank_count         (blank_count),
		.fail_count          (fail_count),
		.conversions_pending (conversions_pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_word(input logic [2:0] f, input logic [63:0] v);
		@(negedge clk);
		start <= 1'b1;
		func <= f;
		raw_value <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	initial begin
		logic [2:0]  f;
		logic [63:0] v;
		arst_n = 1'b0;
		start = 1'b0;
		func = '0;
		raw_value = '0;
		stall_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero in every mode, with junk above the source width
		send_word({1'b0, SRC_8}, 64'd0);
		send_word({1'b1, SRC_8}, 64'hFFFF_FFFF_FFFF_FF00);
		send_word({1'b0, SRC_16}, 64'hA5A5_A5A5_A5A5_0000);
		send_word({1'b1, SRC_16}, 64'd0);
		send_word({1'b0, SRC_32}, 64'hFFFF_FFFF_0000_0000);
		send_word({1'b1, SRC_32}, 64'd0);
		send_word({1'b0, SRC_64}, 64'd0);
		send_word({1'b1, SRC_64}, 64'd0);
		// unsigned maxima
		send_word({1'b0, SRC_8}, 64'hFF);
		send_word({1'b0, SRC_16}, 64'hFFFF);
		send_word({1'b0, SRC_32}, 64'hFFFF_FFFF);
		send_word({1'b0, SRC_64}, 64'hFFFF_FFFF_FFFF_FFFF);
		// most negative signed values
		send_word({1'b1, SRC_8}, 64'h80);
		send_word({1'b1, SRC_16}, 64'h8000);
		send_word({1'b1, SRC_32}, 64'h8000_0000);
		send_word({1'b1, SRC_64}, 64'h8000_0000_0000_0000);
		// minus one and signed maxima
		send_word({1'b1, SRC_8}, 64'hFF);
		send_word({1'b1, SRC_64}, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word({1'b1, SRC_8}, 64'h7F);
		send_word({1'b1, SRC_32}, 64'h7FFF_FFFF);
		send_word({1'b1, SRC_64}, 64'h7FFF_FFFF_FFFF_FFFF);
		// decimal carry boundaries at the top digits and at four digits
		send_word({1'b0, SRC_64}, 64'd9999999999999999999);
		send_word({1'b0, SRC_64}, 64'd10000000000000000000);
		send_word({1'b0, SRC_16}, 64'd9999);
		send_word({1'b0, SRC_16}, 64'd10000);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			f = 3'($urandom_range(0, 7));
			v = {$urandom, $urandom};
			// spread the magnitudes so every digit count shows up
			case ($urandom_range(0, 3))
				0: v = v >> $urandom_range(0, 63);
				1: v = ~(v >> $urandom_range(0, 63));
				default: ;
			endcase
			if (n < RANDOM_WORDS - QUIET_WORDS && $urandom_range(0, 3) == 0)
				hold_off($urandom_range(1, 15));
			send_word(f, v);
		end
		@(negedge clk);
		start <= 1'b0;

		wait (conversions_pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
